[rtl/stce_pkg.sv]
package stce_pkg;

  // Counter limit: MAX_SPRITES, clipped to what nine bits can hold
  localparam int unsigned MAX_SPRITES = 256;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned CAP_INT     = (MAX_SPRITES > 511) ? 511 : MAX_SPRITES;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_SELECT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_COLOUR_SOURCE = 2'd1;

  // Attribute word fields
  localparam int unsigned ATTR_FLIP_X = 0;
  localparam int unsigned ATTR_FLIP_Y = 1;
  localparam int unsigned ATTR_ENABLE = 2;
  localparam logic [7:0]  COLOUR_BASE = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } stce_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } stce_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
  } stce_stat_t;

endpackage

[rtl/stce_ctrl.sv]
module stce_ctrl
  import stce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  stce_stat_t stat_i,
  output stce_cmd_t  cmd_o
);

  stce_state_e state_q, state_d;

  // Sequence: take one request, then hand out its results one by one
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_load_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && stat_i.last) |=> in_ready_o)
    else $error("block not idle after final result");
`endif

endmodule

[rtl/stce_datapath.sv]
module stce_datapath
  import stce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [1:0]           cfg_data_i,
  input  stce_cmd_t            cmd_i,
  output stce_stat_t           stat_o,
  input  logic [15:0]          attr_word_i,
  input  logic [15:0]          code_word_i,
  input  logic [15:0]          size_word_i,
  input  logic [15:0]          ypos_word_i,
  input  logic [15:0]          xpos_word_i,
  input  logic                 frame_start_i,
  output logic                 draw_valid_o,
  output logic [16:0]          tile_code_o,
  output logic [7:0]           palette_colour_o,
  output logic [16:0]          tile_x_o,
  output logic [16:0]          tile_y_o,
  output logic                 flip_horizontal_o,
  output logic                 flip_vertical_o,
  output logic [CNT_W-1:0]     matched_total_o,
  output logic                 last_of_run_o
);

  logic [1:0]       prio_q;
  logic             alt_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      code_q, xpos_q, ypos_q;
  logic [3:0]       colour_q;
  logic [2:0]       size_m1_q, size_m1_d;
  logic             fx_q, fy_q, empty_q;
  logic [2:0]       row_q, row_d, col_q, col_d;
  logic             match;
  logic [CNT_W-1:0] cnt_base;
  logic [2:0]       cx, cy;
  logic [5:0]       morton;
  logic             last;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= '0;
      alt_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PRIORITY_SELECT) begin
        prio_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_ALT_COLOUR_SOURCE) begin
        alt_q <= cfg_data_i[0];
      end
    end
  end

  // Match test and matched count update
  assign match    = attr_word_i[ATTR_ENABLE] && (attr_word_i[5:4] == prio_q);
  assign cnt_base = frame_start_i ? '0 : cnt_q;
  always_comb begin
    cnt_d = cnt_base;
    if (match && (cnt_base < COUNT_CAP)) begin
      cnt_d = cnt_base + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= cnt_d;
    end
  end

  // Size in tiles minus one
  always_comb begin
    unique case (size_word_i[1:0])
      2'd0:    size_m1_d = 3'd0;
      2'd1:    size_m1_d = 3'd1;
      2'd2:    size_m1_d = 3'd3;
      default: size_m1_d = 3'd7;
    endcase
  end

  // Hold the sprite fields for the whole run
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q    <= code_word_i;
      xpos_q    <= xpos_word_i;
      ypos_q    <= ypos_word_i;
      colour_q  <= alt_q ? attr_word_i[7:4] : size_word_i[7:4];
      size_m1_q <= size_m1_d;
      fx_q      <= attr_word_i[ATTR_FLIP_X];
      fy_q      <= attr_word_i[ATTR_FLIP_Y];
      empty_q   <= !match;
    end
  end

  // Advance the row-major tile position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.load) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.step) begin
      if (col_q == size_m1_q) begin
        col_d = '0;
        row_d = row_q + 3'd1;
      end else begin
        col_d = col_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Form the current command
  assign cx     = fx_q ? (size_m1_q ^ col_q) : col_q;
  assign cy     = fy_q ? (size_m1_q ^ row_q) : row_q;
  assign morton = {row_q[2], col_q[2], row_q[1], col_q[1], row_q[0], col_q[0]};
  assign last   = empty_q || ((row_q == size_m1_q) && (col_q == size_m1_q));

  assign stat_o.last       = last;
  assign draw_valid_o      = !empty_q;
  assign tile_code_o       = empty_q ? '0 : ({1'b0, code_q} + {11'b0, morton});
  assign palette_colour_o  = empty_q ? '0 : (COLOUR_BASE | {4'b0, colour_q});
  assign tile_x_o          = empty_q ? '0 : ({1'b0, xpos_q} + {11'b0, cx, 3'b0});
  assign tile_y_o          = empty_q ? '0 : ({1'b0, ypos_q} + {11'b0, cy, 3'b0});
  assign flip_horizontal_o = !empty_q && fx_q;
  assign flip_vertical_o   = !empty_q && fy_q;
  assign matched_total_o   = cnt_q;
  assign last_of_run_o     = last;

`ifndef SYNTH
  a_cnt_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= COUNT_CAP)
    else $error("matched counter beyond its limit");
`endif

endmodule

[rtl/sprite_tile_command_expander_core.sv]
// Channel   Dir  Content
// s_axis    in   tdata: attr, code, size, ypos, xpos words; tuser: frame_start
// m_axis    out  tdata: tile command; tuser: draw_valid; tlast: last_of_run
// cfg       in   register writes: priority_select, alt_colour_source
//
// A request is taken, then its results follow one per cycle while m_axis is ready:
// S*S results for a matching sprite (1 to 64), one empty result otherwise.
// One request is in flight at a time; the tile row/column counter sets the rate.
// Reset (asynchronous, active low) clears state, settings, tile position, count.
// A stall on m_axis holds the current result; s_axis is not ready until the
// last result of a request has been taken.
module sprite_tile_command_expander_core
  import stce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // attr_word[15:0], code_word[31:16], size_word[47:32], ypos_word[63:48],
  // xpos_word[79:64]
  input  logic [79:0]          s_axis_tdata,
  // frame_start[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tile_code[16:0], palette_colour[24:17], tile_x[41:25], tile_y[58:42],
  // flip_horizontal[59], flip_vertical[60], matched_total[69:61], zero[71:70]
  output logic [71:0]          m_axis_tdata,
  // draw_valid[0]
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [1:0]           cfg_data_i
);

  stce_cmd_t        cmd;
  stce_stat_t       stat;
  logic [16:0]      tile_code, tile_x, tile_y;
  logic [7:0]       palette_colour;
  logic             flip_h, flip_v;
  logic [CNT_W-1:0] matched_total;

  stce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stce_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .attr_word_i       (s_axis_tdata[15:0]),
    .code_word_i       (s_axis_tdata[31:16]),
    .size_word_i       (s_axis_tdata[47:32]),
    .ypos_word_i       (s_axis_tdata[63:48]),
    .xpos_word_i       (s_axis_tdata[79:64]),
    .frame_start_i     (s_axis_tuser),
    .draw_valid_o      (m_axis_tuser),
    .tile_code_o       (tile_code),
    .palette_colour_o  (palette_colour),
    .tile_x_o          (tile_x),
    .tile_y_o          (tile_y),
    .flip_horizontal_o (flip_h),
    .flip_vertical_o   (flip_v),
    .matched_total_o   (matched_total),
    .last_of_run_o     (m_axis_tlast)
  );

  // Pack the result word
  assign m_axis_tdata = {2'b00, matched_total, flip_v, flip_h, tile_y, tile_x,
                         palette_colour, tile_code};

endmodule

[tb/sv/tile_command_checker.sv]
`timescale 1ns / 100ps

// Watches the request, result and register channels of the tile command
// expander, works out the tile commands each request should produce and
// compares them, field by field, with what comes out.
module tile_command_checker
  import stce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // attr_word[15:0], code_word[31:16], size_word[47:32], ypos_word[63:48],
  // xpos_word[79:64]
  input  logic [79:0]          s_axis_tdata,
  // frame_start[0]
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tile_code[16:0], palette_colour[24:17], tile_x[41:25], tile_y[58:42],
  // flip_horizontal[59], flip_vertical[60], matched_total[69:61], zero[71:70]
  input  logic [71:0]          m_axis_tdata,
  // draw_valid[0]
  input  logic                 m_axis_tuser,
  input  logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [1:0]           cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic             draw;
    logic [16:0]      code;
    logic [7:0]       colour;
    logic [16:0]      x;
    logic [16:0]      y;
    logic             flip_h;
    logic             flip_v;
    logic [CNT_W-1:0] matched;
    logic             last;
  } tile_cmd_t;

  tile_cmd_t        pending_tiles[$];
  logic [1:0]       prio_sel;
  logic             alt_colour;
  logic [CNT_W-1:0] matched_count;
  int unsigned      fails;

  initial fails = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    $display("%0t ns: tile command %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Expand one sprite entry into its tile commands, or one empty result
  task automatic expand_sprite(input logic [79:0] word, input logic frame_start);
    logic [15:0] attr;
    logic [15:0] code;
    logic [15:0] sizew;
    logic [15:0] ypos;
    logic [15:0] xpos;
    logic [7:0]  colour;
    logic [5:0]  offset;
    int unsigned span;
    int unsigned cx;
    int unsigned cy;
    tile_cmd_t   cmd;
    attr  = word[15:0];
    code  = word[31:16];
    sizew = word[47:32];
    ypos  = word[63:48];
    xpos  = word[79:64];
    if (frame_start)
      matched_count = '0;
    cmd = '0;
    if (!attr[ATTR_ENABLE] || attr[5:4] != prio_sel) begin
      cmd.matched = matched_count;
      cmd.last    = 1'b1;
      pending_tiles.push_back(cmd);
    end else begin
      if (matched_count < COUNT_CAP)
        matched_count++;
      colour = COLOUR_BASE | {4'h0, alt_colour ? attr[7:4] : sizew[7:4]};
      span   = 1 << sizew[1:0];
      for (int row = 0; row < span; row++) begin
        for (int col = 0; col < span; col++) begin
          // column bits on even positions, row bits on odd
          for (int b = 0; b < 3; b++) begin
            offset[2*b]   = col[b];
            offset[2*b+1] = row[b];
          end
          cx = attr[ATTR_FLIP_X] ? span - 1 - col : col;
          cy = attr[ATTR_FLIP_Y] ? span - 1 - row : row;
          cmd.draw    = 1'b1;
          cmd.code    = 17'(code) + 17'(offset);
          cmd.colour  = colour;
          cmd.x       = 17'(xpos) + 17'(8 * cx);
          cmd.y       = 17'(ypos) + 17'(8 * cy);
          cmd.flip_h  = attr[ATTR_FLIP_X];
          cmd.flip_v  = attr[ATTR_FLIP_Y];
          cmd.matched = matched_count;
          cmd.last    = (row == span - 1) && (col == span - 1);
          pending_tiles.push_back(cmd);
        end
      end
    end
  endtask

  // Compare one result with the oldest tile command waiting
  task automatic check_tile();
    tile_cmd_t want;
    if (pending_tiles.size() == 0) begin
      report_mismatch("with no request waiting", m_axis_tdata[31:0], '0);
    end else begin
      want = pending_tiles.pop_front();
      if (m_axis_tuser !== want.draw)
        report_mismatch("draw_valid", m_axis_tuser, want.draw);
      if (m_axis_tdata[16:0] !== want.code)
        report_mismatch("tile_code", m_axis_tdata[16:0], want.code);
      if (m_axis_tdata[24:17] !== want.colour)
        report_mismatch("palette_colour", m_axis_tdata[24:17], want.colour);
      if (m_axis_tdata[41:25] !== want.x)
        report_mismatch("tile_x", m_axis_tdata[41:25], want.x);
      if (m_axis_tdata[58:42] !== want.y)
        report_mismatch("tile_y", m_axis_tdata[58:42], want.y);
      if (m_axis_tdata[59] !== want.flip_h)
        report_mismatch("flip_horizontal", m_axis_tdata[59], want.flip_h);
      if (m_axis_tdata[60] !== want.flip_v)
        report_mismatch("flip_vertical", m_axis_tdata[60], want.flip_v);
      if (m_axis_tdata[69:61] !== want.matched)
        report_mismatch("matched_total", m_axis_tdata[69:61], want.matched);
      if (m_axis_tlast !== want.last)
        report_mismatch("last_of_run", m_axis_tlast, want.last);
    end
  endtask

  // Check results before taking a new request: a result never belongs to a
  // request accepted on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_tiles.delete();
      prio_sel      = '0;
      alt_colour    = 1'b0;
      matched_count = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_tile();
      if (s_axis_tvalid && s_axis_tready)
        expand_sprite(s_axis_tdata, s_axis_tuser);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRIORITY_SELECT:   prio_sel   = cfg_data_i;
          CFG_ALT_COLOUR_SOURCE: alt_colour = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o    <= pending_tiles.size();
    fail_count_o <= fails;
  end

endmodule

[tb/sv/sprite_tile_command_expander_core_test.sv]
`timescale 1ns / 100ps

module sprite_tile_command_expander_core_test
  import stce_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned IDLE_PCT        = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [79:0]          s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [71:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [1:0]           cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles    = 0;
  bit          steady    = 1'b0;
  bit          hold_sink = 1'b0;
  logic [1:0]  cur_prio  = '0;

  sprite_tile_command_expander_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  tile_command_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sprite_tile_command_expander_core_test: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_sink = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offer one sprite request, with a random gap ahead of it, and hold it
  // until accepted; valid stays high for a following request
  task automatic send_sprite(input logic [15:0] attr, input logic [15:0] code,
                             input logic [15:0] sizew, input logic [15:0] ypos,
                             input logic [15:0] xpos, input logic frame_start);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {xpos, ypos, sizew, code, attr};
    s_axis_tuser  <= frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait for every tile command still owed
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reconfigure only once the block is idle
  task automatic configure(input logic [1:0] prio, input logic alt);
    drain();
    write_reg(CFG_PRIORITY_SELECT, prio);
    write_reg(CFG_ALT_COLOUR_SOURCE, {1'b0, alt});
    cur_prio = prio;
  endtask

  // Random sprite, forced to match now and then; keep 8x8 sprites rare
  task automatic random_sprite(input int unsigned match_pct, input int unsigned fs_pct,
                               input bit small_only);
    logic [15:0] attr;
    logic [15:0] sizew;
    attr  = 16'($urandom);
    sizew = 16'($urandom);
    if ($urandom_range(0, 99) < match_pct) begin
      attr[ATTR_ENABLE] = 1'b1;
      attr[5:4]         = cur_prio;
    end
    if (small_only)
      sizew[1] = 1'b0;
    else if (sizew[1:0] == 2'd3 && $urandom_range(0, 3) != 0)
      sizew[1:0] = 2'($urandom_range(0, 2));
    send_sprite(attr, 16'($urandom), sizew, 16'($urandom), 16'($urandom),
                $urandom_range(0, 99) < fs_pct);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: priority 0, colour from the size word
    send_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1); // disabled
    send_sprite(16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0); // one tile
    send_sprite(16'h0005, 16'h1234, 16'h0051, 16'h0010, 16'h0020, 1'b0); // 2x2, flip x
    send_sprite(16'h0006, 16'h8000, 16'h00a2, 16'h0100, 16'h0200, 1'b0); // 4x4, flip y
    send_sprite(16'h0007, 16'hffff, 16'hfff3, 16'hffff, 16'hffff, 1'b0); // 8x8, carries
    send_sprite(16'h0044, 16'h0042, 16'h00a0, 16'h0008, 16'h0008, 1'b0); // attribute bit 6
    send_sprite(16'h0014, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 1'b0); // wrong priority
    send_sprite(16'hfffb, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0); // enable clear
    send_sprite(16'h00f4, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0); // priority 3
    send_sprite(16'h000c, 16'h0200, 16'hff00, 16'h0000, 16'h0000, 1'b1); // new frame

    // Priority 3, colour from the attribute word
    configure(2'd3, 1'b1);
    send_sprite(16'hffff, 16'h0000, 16'hfffc, 16'h0000, 16'h0000, 1'b0);
    send_sprite(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
    send_sprite(16'h00b4, 16'h0010, 16'h0001, 16'h7fff, 16'h8000, 1'b0);
    send_sprite(16'h0034, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sprite(16'hffff, 16'hfff0, 16'h0002, 16'hfff8, 16'hfff8, 1'b0);
    send_sprite(16'h0024, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);

    // Spare indexes must leave settings alone; only the low data bit sets the colour source
    drain();
    write_reg(CFG_IDX_SPARE_LO, 2'b11);
    write_reg(CFG_IDX_SPARE_HI, 2'b00);
    write_reg(CFG_ALT_COLOUR_SOURCE, 2'b10);
    send_sprite(16'h00f4, 16'h0300, 16'h00c1, 16'h0040, 16'h0040, 1'b0);
    send_sprite(16'h0304, 16'h0400, 16'h00c0, 16'h0000, 16'h0000, 1'b0);

    // Random requests, a long receiver hold-off and a mid-phase pause
    configure(2'd1, 1'b0);
    for (int i = 0; i < 40; i++) begin
      if (i == 10)
        hold_sink = 1'b1;
      if (i == 25)
        drain();
      random_sprite(60, 10, 1'b0);
    end

    // No idling on either side
    configure(2'd2, 1'b1);
    steady = 1'b1;
    for (int i = 0; i < 20; i++)
      random_sprite(70, 10, 1'b0);
    drain();
    steady = 1'b0;

    // One long frame of small sprites to run the matched count into its limit
    configure(2'd3, 1'b1);
    send_sprite(16'h0034, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    for (int i = 0; i < 275; i++)
      random_sprite(98, 0, 1'b1);

    configure(2'd0, 1'b0);
    for (int i = 0; i < 10; i++)
      random_sprite(60, 15, 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("sprite_tile_command_expander_core_test: done, clean");
    else
      $display("sprite_tile_command_expander_core_test: done, errors");
    $finish;
  end

endmodule
